[sv/aes_ofb_pkg.sv]
// Package: AES S-box, xtime helper and shared controller/datapath command types.
`default_nettype none
package aes_ofb_pkg;

  localparam int KEY_W = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 2'd3;

  localparam logic [3:0] LAST_ROUND = 4'd10;

  typedef struct packed {
    logic load_iv;     // reload feedback from IV
    logic init_round;  // add round key 0, load key schedule
    logic do_round;    // run one round
    logic take_ks;     // latch cipher state as keystream and feedback
    logic take_byte;   // capture the byte of the request being accepted
    logic emit;        // combine byte and load output register
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] round_number;
  } dp_status_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r=8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

[sv/aes_ofb_datapath.sv]
// Datapath: config registers, feedback/keystream blocks, one-round-per-cycle AES engine.
`default_nettype none
module aes_ofb_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [63:0]             cfg_data,
  input  wire aes_ofb_pkg::dp_cmd_t    cmd,
  output aes_ofb_pkg::dp_status_t      status,
  input  wire logic [7:0]              in_byte,
  input  wire logic [3:0]              byte_position,
  output logic [7:0]                   out_byte
);
  import aes_ofb_pkg::*;

  logic [127:0] key, iv, feedback, keystream, state, rkey;
  logic [3:0]   round_number;
  logic [7:0]   rcon;
  logic [7:0]   data_hold;

  logic [127:0] fb_sel, rkey_next, sub, shf, mix, round_out;

  // Byte i of a block sits at bits [127-8i -: 8].
  always_comb begin
    logic [7:0] t0, t1, t2, t3, a0, a1, a2, a3, al;
    logic [31:0] w;
    fb_sel = cmd.load_iv ? iv : feedback;
    // next round key from rkey
    t0 = sbox(rkey[23:16]) ^ rcon;
    t1 = sbox(rkey[15:8]);
    t2 = sbox(rkey[7:0]);
    t3 = sbox(rkey[31:24]);
    w = rkey[127:96] ^ {t0, t1, t2, t3};
    rkey_next[127:96] = w;
    w = w ^ rkey[95:64];
    rkey_next[95:64] = w;
    w = w ^ rkey[63:32];
    rkey_next[63:32] = w;
    w = w ^ rkey[31:0];
    rkey_next[31:0] = w;
    for (int i = 0; i < 16; i++) sub[127-8*i -: 8] = sbox(state[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        shf[127-8*(c*4+i) -: 8] = sub[127-8*((((c+i)&3)*4)+i) -: 8];
    for (int c = 0; c < 4; c++) begin
      a0 = shf[127-8*(c*4) -: 8];
      a1 = shf[127-8*(c*4+1) -: 8];
      a2 = shf[127-8*(c*4+2) -: 8];
      a3 = shf[127-8*(c*4+3) -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mix[127-8*(c*4) -: 8]   = a0 ^ al ^ xt(a0 ^ a1);
      mix[127-8*(c*4+1) -: 8] = a1 ^ al ^ xt(a1 ^ a2);
      mix[127-8*(c*4+2) -: 8] = a2 ^ al ^ xt(a2 ^ a3);
      mix[127-8*(c*4+3) -: 8] = a3 ^ al ^ xt(a3 ^ a0);
    end
    round_out = ((round_number == LAST_ROUND - 4'd1) ? shf : mix) ^ rkey_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0; iv <= '0; feedback <= '0; keystream <= '0;
      state <= '0; rkey <= '0; round_number <= '0; rcon <= 8'h01;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_HIGH: key[127:64] <= cfg_data;
          REG_KEY_LOW:  key[63:0]   <= cfg_data;
          REG_IV_HIGH:  iv[127:64]  <= cfg_data;
          REG_IV_LOW:   iv[63:0]    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_iv) feedback <= iv;
      if (cmd.init_round) begin
        state <= fb_sel ^ key;
        rkey <= key;
        rcon <= 8'h01;
        round_number <= '0;
      end else if (cmd.do_round) begin
        state <= round_out;
        rkey <= rkey_next;
        rcon <= xt(rcon);
        round_number <= round_number + 4'd1;
      end
      if (cmd.take_ks) begin
        keystream <= state;
        feedback <= state;
      end
    end
  end

  // Hold the accepted byte while a block encryption runs.
  always_ff @(posedge clk) begin
    if (cmd.take_byte) data_hold <= in_byte;
    if (cmd.emit)
      out_byte <= (cmd.take_byte ? in_byte : data_hold) ^ keystream[127-8*byte_position -: 8];
  end

  assign status.round_number = round_number;
endmodule
`default_nettype wire

[sv/aes_ofb_ctrl.sv]
// Controller: accepts requests, sequences block encryption, holds the output handshake.
`default_nettype none
module aes_ofb_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    start_of_message,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  input  wire aes_ofb_pkg::dp_status_t status,
  output aes_ofb_pkg::dp_cmd_t         cmd,
  output logic [3:0]                   byte_position
);
  import aes_ofb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_TAKE, S_EMIT} state_t;
  state_t st;

  logic accept, out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (st != S_IDLE) || !out_free;
  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    unique case (st)
      S_IDLE: begin
        if (accept) begin
          cmd.load_iv = start_of_message;
          cmd.init_round = start_of_message || (byte_position == 4'd0);
          cmd.take_byte = 1'b1;
          cmd.emit = !cmd.init_round;
        end
      end
      S_ROUND: cmd.do_round = 1'b1;
      S_TAKE:  cmd.take_ks = 1'b1;
      S_EMIT:  cmd.emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; out_valid <= 1'b0; byte_position <= '0;
    end else begin
      // load the output register or drop a drained result
      if (cmd.emit) begin
        out_valid <= 1'b1;
        byte_position <= byte_position + 4'd1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: if (accept && cmd.init_round) begin
          byte_position <= '0;
          st <= S_ROUND;
        end
        S_ROUND: if (status.round_number == LAST_ROUND - 4'd1) st <= S_TAKE;
        S_TAKE: st <= S_EMIT;
        S_EMIT: if (out_free) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[sv/aes128_ofb_stream_cipher_top.sv]
// Top level: AES-128 OFB byte stream cipher.
//
// Input channel: in_valid/in_stall carry one request of start_of_message and
// in_byte. Output channel: out_valid/out_stall carry out_byte, the input
// byte XORed with the next keystream byte.
// Configuration: cfg_we, cfg_index (0 key_high, 1 key_low, 2 iv_high,
// 3 iv_low), cfg_data; write only while idle.
// A byte that is not the first of a block appears in the cycle after
// its request is taken. The first byte of a block (or any byte with
// start_of_message) starts an encryption: the initial key add, ten
// rounds of the shared round unit (one round and one key-schedule step
// per cycle), a step that latches the keystream, then the byte.
// Throughput: one byte per cycle while the receiver does not stall; a
// block-opening byte holds off new requests until its byte is loaded.
// Reset clears the key, IV, feedback, keystream, round engine and byte
// position, and drops out_valid.
// When the receiver stalls, out_byte holds and in_stall rises so no new
// request is taken until the output register drains.
`default_nettype none
module aes128_ofb_stream_cipher_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        start_of_message,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import aes_ofb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [3:0] byte_position;

  aes_ofb_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .start_of_message,
    .out_valid, .out_stall, .status, .cmd, .byte_position
  );

  aes_ofb_datapath u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cmd, .status,
    .in_byte, .byte_position, .out_byte
  );
endmodule
`default_nettype wire

[sv/aes_ofb_checker.sv]
// Checker: port-level assertions for the OFB cipher, bound to the top level.
`default_nettype none
module aes_ofb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte)) else $error("output dropped");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall) else $error("took request with full output");
  a_no_result_without_request: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_stall && !in_valid |=> !out_valid)
    else $error("result without request");
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind aes128_ofb_stream_cipher_top aes_ofb_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_byte
);
`default_nettype wire

[tb/aes128_ofb_stream_cipher_top_tb.sv]
// Testbench for the AES-128 OFB byte stream cipher: directed table and vectors, then random messages.
`timescale 1ns / 1ps
`default_nettype none
module aes128_ofb_stream_cipher_top_tb;
  import aes_ofb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        start_of_message = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = 64'h0;

  aes128_ofb_stream_cipher_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_of_message(start_of_message), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the cipher state, kept at the block's own widths.
  logic [127:0] shadow_key, shadow_iv, shadow_feedback, shadow_keystream;
  logic [3:0]   shadow_pos;

  logic [7:0] expected_bytes[$];
  int         mismatch_count = 0;
  int         mode = 0;        // 0 random gaps, 1 no gaps
  bit         hold_off = 1'b0; // long receiver stall request

  // Hand-built S-box from the GF(2^8) inverse and the affine map.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] subst_byte(input logic [7:0] a);
    logic [7:0] inv, r;
    inv = 8'h00;
    for (int c = 1; c < 256; c++)
      if (gf_mul(a, 8'(c)) == 8'h01) inv = 8'(c);
    for (int i = 0; i < 8; i++)
      r[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
             ^ inv[(i + 7) % 8];
    return r ^ 8'h63;
  endfunction

  logic [7:0] sub_lut[256];
  initial for (int i = 0; i < 256; i++) sub_lut[i] = subst_byte(8'(i));

  function automatic logic [7:0] dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Encrypt one 128-bit block, byte 0 in bits 127:120.
  function automatic logic [127:0] encrypt_block(input logic [127:0] blk,
                                                 input logic [127:0] key);
    logic [7:0] s[16], t[16], k[16], tmp[4];
    logic [7:0] rcon, all;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) begin
      s[i] = blk[127 - 8*i -: 8] ^ key[127 - 8*i -: 8];
      k[i] = key[127 - 8*i -: 8];
    end
    for (int r = 1; r <= 10; r++) begin
      // advance the key schedule by one round
      tmp[0] = sub_lut[k[13]] ^ rcon; tmp[1] = sub_lut[k[14]];
      tmp[2] = sub_lut[k[15]];        tmp[3] = sub_lut[k[12]];
      rcon = dbl(rcon);
      for (int w = 0; w < 4; w++)
        for (int j = 0; j < 4; j++) begin
          k[4*w + j] ^= tmp[j];
          tmp[j] = k[4*w + j];
        end
      for (int i = 0; i < 16; i++) s[i] = sub_lut[s[i]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[4*c + i] = s[((c + i) % 4) * 4 + i];
      for (int c = 0; c < 4; c++) begin
        if (r < 10) begin
          all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
          for (int i = 0; i < 4; i++)
            s[4*c + i] = t[4*c + i] ^ all ^ dbl(t[4*c + i] ^ t[4*c + (i + 1) % 4]);
        end else begin
          for (int i = 0; i < 4; i++) s[4*c + i] = t[4*c + i];
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= k[i];
    end
    for (int i = 0; i < 16; i++) blk[127 - 8*i -: 8] = s[i];
    return blk;
  endfunction

  // Advance the shadow by one accepted request and return the cipher byte.
  function automatic logic [7:0] predict_cipher_byte(input logic som, input logic [7:0] b);
    if (som) begin
      shadow_feedback = shadow_iv;
      shadow_pos = 4'd0;
    end
    if (shadow_pos == 4'd0) begin
      shadow_keystream = encrypt_block(shadow_feedback, shadow_key);
      shadow_feedback = shadow_keystream;
    end
    predict_cipher_byte = b ^ shadow_keystream[127 - 8*shadow_pos -: 8];
    shadow_pos = shadow_pos + 4'd1;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_HIGH: shadow_key[127:64] = val;
      REG_KEY_LOW:  shadow_key[63:0]   = val;
      REG_IV_HIGH:  shadow_iv[127:64]  = val;
      default:      shadow_iv[63:0]    = val;
    endcase
  endtask

  // Offer one request from a falling edge, hold it until taken; expected is
  // typed in when check_known is set, otherwise taken from the predictor.
  // Valid stays high after the request is taken; at that falling edge the
  // next request replaces it, or a gap before it or a drain drops it.
  task automatic send_byte(input logic som, input logic [7:0] b,
                           input bit check_known, input logic [7:0] known);
    logic [7:0] pred;
    while (mode == 0 && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; start_of_message <= som; in_byte <= b;
    do @(posedge clk); while (in_stall);
    pred = predict_cipher_byte(som, b);
    if (check_known && pred != known)
      $display("table row disagrees with predictor: %h vs %h", known, pred);
    expected_bytes = {expected_bytes, (check_known ? known : pred)};
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // Receiver: drive stall on falling edges.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_off) out_stall <= 1'b1;
      else out_stall <= (mode == 0) && ($urandom_range(0, 99) < 24);
      @(negedge clk);
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected output byte %h", out_byte);
      end else begin
        if (out_byte !== expected_bytes[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("out_byte mismatch: expected %h actual %h", expected_bytes[0], out_byte);
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  typedef struct {
    logic       som;
    logic [7:0] data;
    bit         known;
    logic [7:0] result;
  } stim_row_t;

  // FIPS-197 vector: key 000102..0f, block 00112233..ff -> 69c4e0d8..c55a.
  // Zero key and IV, first keystream byte is 0x66 (AES of zero under zero key).
  stim_row_t dir_rows[$] = '{
    '{1'b0, 8'h00, 1'b1, 8'h66}, // no start after reset: zero feedback block
    '{1'b0, 8'hff, 1'b1, 8'h16}, // 66e94bd4: second byte e9 ^ ff
    '{1'b0, 8'h80, 1'b0, 8'h00},
    '{1'b1, 8'h01, 1'b1, 8'h67}, // start mid-block reloads zero IV
    '{1'b0, 8'h7f, 1'b0, 8'h00}
  };

  initial begin
    logic som;
    shadow_key = '0; shadow_iv = '0; shadow_feedback = '0;
    shadow_keystream = '0; shadow_pos = 4'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_byte(dir_rows[i].som, dir_rows[i].data, dir_rows[i].known, dir_rows[i].result);
    // run the rest of the block, through its last byte position
    for (int i = 0; i < 14; i++) send_byte(1'b0, 8'(i * 37), 1'b0, 8'h00);
    drain_and_settle();

    // FIPS key with IV equal to the FIPS plaintext; zero data exposes the keystream.
    write_reg(REG_KEY_HIGH, 64'h0001020304050607);
    write_reg(REG_KEY_LOW,  64'h08090a0b0c0d0e0f);
    write_reg(REG_IV_HIGH,  64'h0011223344556677);
    write_reg(REG_IV_LOW,   64'h8899aabbccddeeff);
    send_byte(1'b1, 8'h00, 1'b1, 8'h69);
    send_byte(1'b0, 8'h00, 1'b1, 8'hc4);
    send_byte(1'b0, 8'hff, 1'b1, 8'h1f); // e0 ^ ff
    drain_and_settle();

    // All-ones extremes, and a key change mid-block taking effect next block.
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW,  '1);
    write_reg(REG_IV_HIGH,  '1);
    write_reg(REG_IV_LOW,   '1);
    for (int i = 0; i < 5; i++) send_byte(i == 0, 8'hff, 1'b0, 8'h00);
    drain_and_settle();
    write_reg(REG_KEY_LOW, 64'h0123456789abcdef);
    for (int i = 0; i < 14; i++) send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
    drain_and_settle();

    // Random messages in phases with fresh key and IV between them.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_KEY_HIGH, {$urandom, $urandom});
      write_reg(REG_KEY_LOW,  {$urandom, $urandom});
      write_reg(REG_IV_HIGH,  {$urandom, $urandom});
      write_reg(REG_IV_LOW,   {$urandom, $urandom});
      mode = (ph == 3) ? 1 : 0;
      if (ph == 5) fork
        begin
          hold_off = 1'b1;
          repeat (200) @(negedge clk);
          hold_off = 1'b0;
        end
      join_none
      for (int n = 0; n < 160; n++) begin
        // mostly long messages; sometimes a start mid-block
        som = (n == 0) || ($urandom_range(0, 99) < 4);
        send_byte(som, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
      end
      mode = 0;
      drain_and_settle();
    end

    if (mismatch_count == 0 && expected_bytes.size() == 0)
      $display("aes128_ofb_stream_cipher_top_tb: PASS");
    else
      $display("aes128_ofb_stream_cipher_top_tb: FAIL");
    $finish;
  end

  initial begin
    #3ms;
    $display("aes128_ofb_stream_cipher_top_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
